// ----- src/hptd_pkg.sv -----
// shared constants and types for the high-pass triangular dither core
package hptd_pkg;

    localparam int SAMPLE_W = 32;
    localparam int OUT_W    = 16;
    localparam int NOISE_W  = 9;
    localparam int CFG_W    = 3;

    localparam logic [31:0] LCG_MUL   = 32'd96314165;
    localparam logic [31:0] LCG_ADD   = 32'd907633515;
    localparam logic [31:0] LCG_RESET = 32'd22222;

    localparam logic [CFG_W-1:0] CFG_RESET = 3'd1;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -16'sh8000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [OUT_W-1:0]    t_out;
    typedef logic signed [NOISE_W-1:0]  t_noise;

endpackage

// ----- src/highpass_triangular_dither_core.sv -----
// top level of the high-pass triangular dither core, 32-bit samples to 16-bit
// pipeline: a stage-1 register holds the input, the output register the result
// throughput: one item per cycle unless the output stalls, set by the seed multiply-add
//   feedback loop and the previous-noise ram read-modify-write, which forwards back-to-back hits
// reset: synchronous active low; seed, channel index, count and the per-entry
//   valid bits are reset at once, no clearing pass over the ram
module highpass_triangular_dither_core #(
    parameter int MAX_CHANNELS_P = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,   // channel_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // sample_in
    input  logic        s_axis_tlast,    // block_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // sample_out
);

    localparam int CH_W = (MAX_CHANNELS_P > 1) ? $clog2(MAX_CHANNELS_P) : 1;
    localparam int CW   = (CH_W + 1 > hptd_pkg::CFG_W) ? CH_W + 1 : hptd_pkg::CFG_W;
    localparam int ACC_W = hptd_pkg::SAMPLE_W + 2;
    localparam int SH_W  = ACC_W - 8;

    logic [31:0]                   r_seed;
    logic [CH_W-1:0]               r_ch;
    logic [hptd_pkg::CFG_W-1:0]    r_cfg;
    logic [MAX_CHANNELS_P-1:0]     r_vld;

    logic                          r_s1_v;
    hptd_pkg::t_sample             r_s1_sample;
    hptd_pkg::t_noise              r_s1_noise;
    logic [CH_W-1:0]               r_s1_ch;
    logic                          r_s1_hit;
    hptd_pkg::t_noise              r_s1_fwd;
    logic                          r_s1_pvld;

    logic                          r_out_v;
    hptd_pkg::t_out                r_out_data;

    logic                          in_acc;
    logic                          s1_adv;
    logic [31:0]                   n_seed;
    hptd_pkg::t_noise              n_noise;
    logic [CW-1:0]                 cfg_ext;
    logic [CW-1:0]                 eff_cnt;
    logic [CW-1:0]                 ch_inc;
    logic [CH_W-1:0]               n_ch;
    logic [hptd_pkg::NOISE_W-1:0]  rd_data;
    hptd_pkg::t_noise              prev;
    logic signed [ACC_W-1:0]       acc;
    logic signed [SH_W-1:0]        sh;
    hptd_pkg::t_out                sat;

    assign s1_adv        = r_s1_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_s1_v || s1_adv);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign n_seed  = r_seed * hptd_pkg::LCG_MUL + hptd_pkg::LCG_ADD;
    assign n_noise = {~n_seed[8], n_seed[7:0]};

    always_comb begin
        cfg_ext = CW'(r_cfg);
        if (cfg_ext == '0) begin
            eff_cnt = CW'(1);
        end else if (cfg_ext > CW'(MAX_CHANNELS_P)) begin
            eff_cnt = CW'(MAX_CHANNELS_P);
        end else begin
            eff_cnt = cfg_ext;
        end
        ch_inc = CW'(r_ch) + CW'(1);
        if (s_axis_tlast || ch_inc >= eff_cnt) begin
            n_ch = '0;
        end else begin
            n_ch = ch_inc[CH_W-1:0];
        end
    end

    hptd_ram #(
        .WIDTH (hptd_pkg::NOISE_W),
        .DEPTH (MAX_CHANNELS_P)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_ch),
        .i_wr_data (r_s1_noise),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_ch),
        .o_rd_data (rd_data)
    );

    always_comb begin
        if (r_s1_hit) begin
            prev = r_s1_fwd;
        end else if (r_s1_pvld) begin
            prev = hptd_pkg::t_noise'(rd_data);
        end else begin
            prev = '0;
        end
        acc = ACC_W'(r_s1_sample) + ACC_W'(r_s1_noise) - ACC_W'(prev);
        sh  = acc[ACC_W-1:8];
        if (!sh[SH_W-1] && (|sh[SH_W-2:15])) begin
            sat = hptd_pkg::OUT_MAX;
        end else if (sh[SH_W-1] && !(&sh[SH_W-2:15])) begin
            sat = hptd_pkg::OUT_MIN;
        end else begin
            sat = sh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= hptd_pkg::LCG_RESET;
            r_ch    <= '0;
            r_cfg   <= hptd_pkg::CFG_RESET;
            r_vld   <= '0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (s1_adv) begin
                r_vld[r_s1_ch] <= 1'b1;
            end
            if (in_acc) begin
                r_seed <= n_seed;
                r_ch   <= n_ch;
            end
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample <= s_axis_tdata;
            r_s1_noise  <= n_noise;
            r_s1_ch     <= r_ch;
            r_s1_hit    <= s1_adv && (r_s1_ch == r_ch);
            r_s1_fwd    <= r_s1_noise;
            r_s1_pvld   <= r_vld[r_ch];
        end
        if (s1_adv) begin
            r_out_data <= sat;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- src/hptd_ram.sv -----
// generic single-write single-read ram with registered read data
module hptd_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/hptd_checker.sv -----
// port-level assertions for the high-pass triangular dither core, with bind
module hptd_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [hptd_pkg::OUT_W-1:0] m_axis_tdata
);

    // a stalled result item stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // nothing shows right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item valid after reset");

    // a fresh result item follows an accepted input item via stage 1 and the output register
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result item without input item");

    // a ready sink never throttles the input
    a_full_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

endmodule

bind highpass_triangular_dither_core hptd_checker u_hptd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/highpass_triangular_dither_checker.sv -----
// checker for the dither core: predicts each output sample and compares it on the output channel
`timescale 1ns / 1ps

module highpass_triangular_dither_checker #(
    parameter int MAX_CHANNELS_P = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [hptd_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  hptd_pkg::t_sample          i_in_sample,
    input  logic                       i_in_last,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [hptd_pkg::OUT_W-1:0] i_out_sample,
    output int                         o_fail_count,
    output int                         o_pending
);

    logic [31:0]                seed_model;
    hptd_pkg::t_noise           prev_noise_model [MAX_CHANNELS_P];
    int                         chan_idx_model;
    logic [hptd_pkg::CFG_W-1:0] chan_count_model;
    hptd_pkg::t_out             expected_samples [$];
    hptd_pkg::t_out             oldest;

    function automatic hptd_pkg::t_out dithered_sample(input hptd_pkg::t_sample smp,
                                                       input logic last);
        int     count;
        int     ch;
        int     noise;
        longint acc;
        count = chan_count_model;
        if (count == 0) begin
            count = 1;
        end
        if (count > MAX_CHANNELS_P) begin
            count = MAX_CHANNELS_P;
        end
        ch = chan_idx_model;
        seed_model = seed_model * hptd_pkg::LCG_MUL + hptd_pkg::LCG_ADD;
        noise = int'(seed_model[8:0]) - 256;
        acc = longint'(smp) + longint'(noise) - longint'(prev_noise_model[ch]);
        prev_noise_model[ch] = hptd_pkg::t_noise'(noise);
        acc = acc >>> 8;
        if (acc > longint'(hptd_pkg::OUT_MAX)) begin
            acc = longint'(hptd_pkg::OUT_MAX);
        end
        if (acc < longint'(hptd_pkg::OUT_MIN)) begin
            acc = longint'(hptd_pkg::OUT_MIN);
        end
        chan_idx_model = (last || ch + 1 >= count) ? 0 : ch + 1;
        return hptd_pkg::t_out'(acc);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_model       = hptd_pkg::LCG_RESET;
            chan_idx_model   = 0;
            chan_count_model = hptd_pkg::CFG_RESET;
            for (int i = 0; i < MAX_CHANNELS_P; i++) begin
                prev_noise_model[i] = '0;
            end
            expected_samples.delete();
        end else begin
            if (i_cfg_wr_en) begin
                chan_count_model = i_cfg_wr_data;
            end
            if (i_in_valid && i_in_ready) begin
                expected_samples.push_back(dithered_sample(i_in_sample, i_in_last));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample_out: expected none, actual %0d", $signed(i_out_sample));
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    oldest = expected_samples.pop_front();
                    if (i_out_sample !== oldest) begin
                        $error("sample_out: expected %0d, actual %0d",
                               oldest, $signed(i_out_sample));
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_samples.size();
    end

endmodule

// ----- bench/highpass_triangular_dither_core_test.sv -----
// testbench top for the dither core: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module highpass_triangular_dither_core_test;

    localparam int MAX_CHANNELS_P = 4;
    localparam int CYCLE_LIMIT    = 100000;
    localparam int LONG_HOLD      = 300;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [hptd_pkg::CFG_W-1:0] i_cfg_wr_data;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [31:0]                s_axis_tdata;
    logic                       s_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [15:0]                m_axis_tdata;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int sink_stall  = 0;
    bit sink_gaps   = 1'b1;
    bit hold_request = 1'b0;

    always #10 i_clk = ~i_clk;

    highpass_triangular_dither_core #(
        .MAX_CHANNELS_P(MAX_CHANNELS_P)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    highpass_triangular_dither_checker #(
        .MAX_CHANNELS_P(MAX_CHANNELS_P)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_sample   (s_axis_tdata),
        .i_in_last     (s_axis_tlast),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_sample  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                sink_stall   = LONG_HOLD;
            end
            if (sink_stall > 0) begin
                m_axis_tready <= 1'b0;
                sink_stall--;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                sink_stall = $urandom_range(0, 5);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input hptd_pkg::t_sample smp, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic sender_gap(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_channel_count(input logic [hptd_pkg::CFG_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic hptd_pkg::t_sample random_sample();
        int pick;
        pick = $urandom_range(0, 4);
        case (pick)
            0: return hptd_pkg::t_sample'($urandom);
            1: return hptd_pkg::t_sample'(int'($urandom_range(0, 8191)) - 4096);
            2: return hptd_pkg::t_sample'(8388352 + int'($urandom_range(0, 1023)) - 512);
            3: return hptd_pkg::t_sample'(-8388608 + int'($urandom_range(0, 1023)) - 512);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sh00000000;
                    default: return 32'shffffffff;
                endcase
            end
        endcase
    endfunction

    task automatic run_phase(input logic [hptd_pkg::CFG_W-1:0] count, input int n,
                             input bit gaps, input bit hold);
        write_channel_count(count);
        if (hold) begin
            hold_request = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            send_item(random_sample(), $urandom_range(0, 7) == 0);
            if (gaps && $urandom_range(0, 3) == 0) begin
                sender_gap($urandom_range(1, 6));
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count of one, field extremes and saturation edges
        send_item(32'sh00000000, 1'b0);
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'shffffffff, 1'b1);
        send_item(32'sd255, 1'b0);
        send_item(32'sd256, 1'b0);
        send_item(-32'sd256, 1'b0);
        send_item(32'sh007fff00, 1'b0);
        send_item(32'sh007fffff, 1'b0);
        send_item(32'shff800000, 1'b0);
        send_item(32'shff7fffff, 1'b0);
        drain();

        // block end mid-frame, then leave the index on the last channel
        write_channel_count(3'd4);
        send_item(32'sd1000, 1'b0);
        send_item(-32'sd1000, 1'b1);
        send_item(32'sd2000, 1'b0);
        send_item(32'sd3000, 1'b0);
        send_item(32'sd4000, 1'b0);
        drain();

        // count lowered below the current index
        write_channel_count(3'd2);
        send_item(32'sd6000, 1'b0);
        send_item(32'sd7000, 1'b0);
        drain();

        write_channel_count(3'd0);
        send_item(32'sd100, 1'b0);
        send_item(32'sd200, 1'b0);
        drain();

        write_channel_count(3'd7);
        send_item(32'sd300, 1'b0);
        send_item(32'sd400, 1'b0);
        drain();

        run_phase(3'd4, 70, 1'b1, 1'b0);
        run_phase(3'd2, 60, 1'b0, 1'b1);
        run_phase(3'd7, 60, 1'b1, 1'b0);
        run_phase(3'd3, 60, 1'b1, 1'b0);
        run_phase(3'd0, 50, 1'b1, 1'b0);
        run_phase(3'd5, 50, 1'b1, 1'b0);
        run_phase(3'd6, 50, 1'b1, 1'b0);
        sink_gaps = 1'b0;
        run_phase(3'd1, 50, 1'b0, 1'b0);

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/hptd_pkg.sv
src/hptd_ram.sv
src/highpass_triangular_dither_core.sv
src/hptd_checker.sv
bench/highpass_triangular_dither_checker.sv
bench/highpass_triangular_dither_core_test.sv
